// ----- rtl/dobd_pkg.sv -----
package dobd_pkg;

    // field widths
    localparam int unsigned YearW  = 14;
    localparam int unsigned MonthW = 4;
    localparam int unsigned DayW   = 5;
    localparam int unsigned CountW = 16;
    localparam int unsigned DoyW   = 9;

    // walk registers: signed year and signed day accumulator
    localparam int unsigned WalkYearW = 16;
    localparam int unsigned WalkDayW  = 18;

    // year split into year mod 100 and century mod 4
    localparam int unsigned Mod100W = 7;
    localparam int unsigned QuotW   = 8;
    localparam int unsigned RecipW  = 13;
    localparam int unsigned RecipSh = 19;
    localparam logic [RecipW-1:0] Recip100 = 13'd5243;

    localparam logic [MonthW-1:0] MonthJan = 4'd1;
    localparam logic [MonthW-1:0] MonthFeb = 4'd2;
    localparam logic [MonthW-1:0] MonthDec = 4'd12;
    localparam logic [WalkYearW-1:0] YearMin = 16'd1;
    localparam logic [WalkYearW-1:0] YearMax = 16'd9999;

    localparam logic [0:0] OpAdd = 1'b0;
    localparam logic [0:0] OpSub = 1'b1;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic prep;
        logic split;
        logic check;
        logic step;
        logic publish;
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic walk_done;
    } t_dp_status;

    // gregorian leap rule from low year bits, year mod 100 and century mod 4
    function automatic logic f_is_leap(input logic [1:0] year_lo,
                                       input logic [Mod100W-1:0] mod100,
                                       input logic [1:0] cent);
        logic by4;
        logic cent_zero;
        by4       = (year_lo == 2'd0);
        cent_zero = (mod100 == '0);
        return (by4 && !cent_zero) || (cent_zero && (cent == 2'd0));
    endfunction

    // month length table
    function automatic logic [DayW-1:0] f_month_len(input logic leap,
                                                    input logic [MonthW-1:0] month);
        logic [DayW-1:0] len;
        case (month)
            4'd2:    len = leap ? 5'd29 : 5'd28;
            4'd4:    len = 5'd30;
            4'd6:    len = 5'd30;
            4'd9:    len = 5'd30;
            4'd11:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

    // days in the months before this one, common year
    function automatic logic [DoyW-1:0] f_days_before(input logic [MonthW-1:0] month);
        logic [DoyW-1:0] days;
        case (month)
            4'd2:    days = 9'd31;
            4'd3:    days = 9'd59;
            4'd4:    days = 9'd90;
            4'd5:    days = 9'd120;
            4'd6:    days = 9'd151;
            4'd7:    days = 9'd181;
            4'd8:    days = 9'd212;
            4'd9:    days = 9'd243;
            4'd10:   days = 9'd273;
            4'd11:   days = 9'd304;
            4'd12:   days = 9'd334;
            default: days = 9'd0;
        endcase
        return days;
    endfunction

endpackage

// ----- rtl/dobd_dpath.sv -----
module dobd_dpath (
    input  logic                             i_clk,
    input  dobd_pkg::t_dp_cmd                i_cmd,
    output dobd_pkg::t_dp_status             o_status,
    input  logic                             i_opcode,
    input  logic [dobd_pkg::YearW-1:0]       i_start_year,
    input  logic [dobd_pkg::MonthW-1:0]      i_start_month,
    input  logic [dobd_pkg::DayW-1:0]        i_start_day,
    input  logic [dobd_pkg::CountW-1:0]      i_day_count,
    output logic [dobd_pkg::YearW-1:0]       o_result_year,
    output logic [dobd_pkg::MonthW-1:0]      o_result_month,
    output logic [dobd_pkg::DayW-1:0]        o_result_day,
    output logic [dobd_pkg::DoyW-1:0]        o_start_day_of_year,
    output logic                             o_date_error
);

    localparam int unsigned YW  = dobd_pkg::WalkYearW;
    localparam int unsigned DW  = dobd_pkg::WalkDayW;
    localparam int unsigned MW  = dobd_pkg::Mod100W;
    localparam int unsigned PW  = dobd_pkg::YearW + dobd_pkg::RecipW;

    // working registers
    logic                            r_op;
    logic [YW-1:0]                   r_year;
    logic [dobd_pkg::MonthW-1:0]     r_month;
    logic [DW-1:0]                   r_day;
    logic [dobd_pkg::CountW-1:0]     r_count;
    logic [dobd_pkg::QuotW-1:0]      r_quot;
    logic [MW-1:0]                   r_mod100;
    logic [1:0]                      r_cent;
    logic [dobd_pkg::DoyW-1:0]       r_doy;
    logic                            r_bad;

    // result registers
    logic [dobd_pkg::YearW-1:0]      r_res_year;
    logic [dobd_pkg::MonthW-1:0]     r_res_month;
    logic [dobd_pkg::DayW-1:0]       r_res_day;
    logic [dobd_pkg::DoyW-1:0]       r_res_doy;
    logic                            r_res_err;

    logic [PW-1:0]                   quot_prod;
    logic [dobd_pkg::YearW:0]        cent_prod;
    logic [dobd_pkg::YearW:0]        mod_diff;
    logic                            leap_cur;
    logic [dobd_pkg::DayW-1:0]       len_cur;
    logic                            day_ok;
    logic                            month_ok;
    logic [DW-1:0]                   count_ext;
    logic                            add_more;
    logic                            sub_more;
    logic                            wrap_up;
    logic                            wrap_dn;
    logic [YW-1:0]                   prev_year;
    logic [dobd_pkg::MonthW-1:0]     prev_month;
    logic [MW-1:0]                   prev_mod100;
    logic [1:0]                      prev_cent;
    logic [dobd_pkg::DayW-1:0]       prev_len;
    logic                            year_ok;

    // year / 100 by reciprocal multiply, exact for 14-bit years
    assign quot_prod = PW'(r_year[dobd_pkg::YearW-1:0]) * PW'(dobd_pkg::Recip100);
    assign cent_prod = (dobd_pkg::YearW+1)'(r_quot) * (dobd_pkg::YearW+1)'(7'd100);
    assign mod_diff  = (dobd_pkg::YearW+1)'(r_year[dobd_pkg::YearW-1:0]) - cent_prod;

    // current month length
    assign leap_cur = dobd_pkg::f_is_leap(r_year[1:0], r_mod100, r_cent);
    assign len_cur  = dobd_pkg::f_month_len(leap_cur, r_month);

    // starting date validity
    assign month_ok = (r_month >= dobd_pkg::MonthJan) && (r_month <= dobd_pkg::MonthDec);
    assign day_ok   = (r_day[dobd_pkg::DayW-1:0] != '0)
                   && (r_day[dobd_pkg::DayW-1:0] <= len_cur);
    assign count_ext = DW'(r_count);

    // walk conditions
    assign add_more = $signed(r_day) > $signed(DW'(len_cur));
    assign sub_more = $signed(r_day) < $signed(DW'(1));
    assign wrap_up  = (r_month == dobd_pkg::MonthDec);
    assign wrap_dn  = (r_month == dobd_pkg::MonthJan);

    // previous month for the subtract walk
    always_comb begin
        prev_year   = r_year;
        prev_month  = r_month - 4'd1;
        prev_mod100 = r_mod100;
        prev_cent   = r_cent;
        if (wrap_dn) begin
            prev_year  = r_year - YW'(1);
            prev_month = dobd_pkg::MonthDec;
            if (r_mod100 == '0) begin
                prev_mod100 = MW'(99);
                prev_cent   = r_cent - 2'd1;
            end else begin
                prev_mod100 = r_mod100 - MW'(1);
            end
        end
    end
    assign prev_len = dobd_pkg::f_month_len(
        dobd_pkg::f_is_leap(prev_year[1:0], prev_mod100, prev_cent), prev_month);

    assign o_status.walk_done = r_bad || ((r_op == dobd_pkg::OpSub) ? !sub_more : !add_more);

    assign year_ok = ($signed(r_year) >= $signed(dobd_pkg::YearMin))
                  && ($signed(r_year) <= $signed(dobd_pkg::YearMax));

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_opcode;
            r_year  <= YW'(i_start_year);
            r_month <= i_start_month;
            r_day   <= DW'(i_start_day);
            r_count <= i_day_count;
        end
        if (i_cmd.prep) begin
            r_quot <= quot_prod[PW-1:dobd_pkg::RecipSh];
        end
        if (i_cmd.split) begin
            r_mod100 <= mod_diff[MW-1:0];
            r_cent   <= r_quot[1:0];
        end
        if (i_cmd.check) begin
            r_bad <= !(month_ok && day_ok);
            r_doy <= dobd_pkg::DoyW'(r_day[dobd_pkg::DayW-1:0])
                   + dobd_pkg::f_days_before(r_month)
                   + dobd_pkg::DoyW'(leap_cur && (r_month > dobd_pkg::MonthFeb));
            r_day <= (r_op == dobd_pkg::OpSub) ? (r_day - count_ext) : (r_day + count_ext);
        end
        // one month per cycle
        if (i_cmd.step && !r_bad) begin
            if (r_op == dobd_pkg::OpAdd) begin
                if (add_more) begin
                    r_day <= r_day - DW'(len_cur);
                    if (wrap_up) begin
                        r_month <= dobd_pkg::MonthJan;
                        r_year  <= r_year + YW'(1);
                        if (r_mod100 == MW'(99)) begin
                            r_mod100 <= '0;
                            r_cent   <= r_cent + 2'd1;
                        end else begin
                            r_mod100 <= r_mod100 + MW'(1);
                        end
                    end else begin
                        r_month <= r_month + 4'd1;
                    end
                end
            end else if (sub_more) begin
                r_day    <= r_day + DW'(prev_len);
                r_month  <= prev_month;
                r_year   <= prev_year;
                r_mod100 <= prev_mod100;
                r_cent   <= prev_cent;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.publish) begin
            if (r_bad) begin
                r_res_year  <= '0;
                r_res_month <= '0;
                r_res_day   <= '0;
                r_res_doy   <= '0;
                r_res_err   <= 1'b1;
            end else if (!year_ok) begin
                r_res_year  <= '0;
                r_res_month <= '0;
                r_res_day   <= '0;
                r_res_doy   <= r_doy;
                r_res_err   <= 1'b1;
            end else begin
                r_res_year  <= r_year[dobd_pkg::YearW-1:0];
                r_res_month <= r_month;
                r_res_day   <= r_day[dobd_pkg::DayW-1:0];
                r_res_doy   <= r_doy;
                r_res_err   <= 1'b0;
            end
        end
    end

    assign o_result_year       = r_res_year;
    assign o_result_month      = r_res_month;
    assign o_result_day        = r_res_day;
    assign o_start_day_of_year = r_res_doy;
    assign o_date_error        = r_res_err;

endmodule

// ----- rtl/dobd_ctrl.sv -----
module dobd_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output dobd_pkg::t_dp_cmd     o_cmd,
    input  dobd_pkg::t_dp_status  i_status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_SPLIT,
        S_CHECK,
        S_WALK,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    // next state and commands
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = S_SPLIT;
            end
            S_SPLIT: begin
                o_cmd.split = 1'b1;
                n_state     = S_CHECK;
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = S_WALK;
            end
            S_WALK: begin
                o_cmd.step = 1'b1;
                if (i_status.walk_done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    o_cmd.publish = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ----- rtl/date_offset_by_days.sv -----
// channel   | signals                                        | transfer when
// ----------+------------------------------------------------+-------------------------
// input     | i_in_valid, o_in_stall, i_opcode, i_start_*,   | i_in_valid && !o_in_stall
//           | i_day_count                                    |
// output    | o_out_valid, i_out_stall, o_result_*,          | o_out_valid && !i_out_stall
//           | o_start_day_of_year, o_date_error              |
//
// an accepted input goes through load, prep, split, check, the month walk over every month
// boundary crossed (up to about 2160) and finish; the controller then takes input again
// the month walk steps one month per cycle through the month-length table
// one item in flight; the output register frees the input side while a result waits
// a finished item waits only while the previous result is still stalled
// synchronous active-low reset clears the controller and output valid
module date_offset_by_days (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_opcode,
    input  logic [dobd_pkg::YearW-1:0]        i_start_year,
    input  logic [dobd_pkg::MonthW-1:0]       i_start_month,
    input  logic [dobd_pkg::DayW-1:0]         i_start_day,
    input  logic [dobd_pkg::CountW-1:0]       i_day_count,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [dobd_pkg::YearW-1:0]        o_result_year,
    output logic [dobd_pkg::MonthW-1:0]       o_result_month,
    output logic [dobd_pkg::DayW-1:0]         o_result_day,
    output logic [dobd_pkg::DoyW-1:0]         o_start_day_of_year,
    output logic                              o_date_error
);

    dobd_pkg::t_dp_cmd    cmd;
    dobd_pkg::t_dp_status status;

    // sequencer
    dobd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    // date arithmetic
    dobd_dpath u_dpath (
        .i_clk               (i_clk),
        .i_cmd               (cmd),
        .o_status            (status),
        .i_opcode            (i_opcode),
        .i_start_year        (i_start_year),
        .i_start_month       (i_start_month),
        .i_start_day         (i_start_day),
        .i_day_count         (i_day_count),
        .o_result_year       (o_result_year),
        .o_result_month      (o_result_month),
        .o_result_day        (o_result_day),
        .o_start_day_of_year (o_start_day_of_year),
        .o_date_error        (o_date_error)
    );

endmodule

// ----- rtl/dobd_chk.sv -----
module dobd_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_stall,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic [dobd_pkg::YearW-1:0]        o_result_year,
    input logic [dobd_pkg::MonthW-1:0]       o_result_month,
    input logic [dobd_pkg::DayW-1:0]         o_result_day,
    input logic [dobd_pkg::DoyW-1:0]         o_start_day_of_year,
    input logic                              o_date_error
);

    // an accepted item blocks the input until its result is produced
    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after transfer");

    // stalled result holds
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_result_year)
            && $stable(o_result_month) && $stable(o_result_day)
            && $stable(o_start_day_of_year) && $stable(o_date_error)))
        else $error("stalled result changed");

    // a good result has its year, month and day of year in range and a nonzero day
    a_good_date: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_date_error) |->
            (o_result_year >= 14'd1) && (o_result_year <= 14'd9999)
            && (o_result_month >= 4'd1) && (o_result_month <= 4'd12)
            && (o_result_day >= 5'd1) && (o_start_day_of_year >= 9'd1)
            && (o_start_day_of_year <= 9'd366))
        else $error("good result out of range");

    // an error result carries a zero date
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_date_error) |->
            (o_result_year == '0) && (o_result_month == '0) && (o_result_day == '0))
        else $error("error result with nonzero date");

endmodule

bind date_offset_by_days dobd_chk u_dobd_chk (.*);

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

module tb;

    // one request and one result, at the port widths
    typedef struct packed {
        logic                        op;
        logic [dobd_pkg::YearW-1:0]  year;
        logic [dobd_pkg::MonthW-1:0] month;
        logic [dobd_pkg::DayW-1:0]   day;
        logic [dobd_pkg::CountW-1:0] count;
    } t_date_req;

    typedef struct packed {
        logic [dobd_pkg::YearW-1:0]  year;
        logic [dobd_pkg::MonthW-1:0] month;
        logic [dobd_pkg::DayW-1:0]   day;
        logic [dobd_pkg::DoyW-1:0]   doy;
        logic                        err;
    } t_date_res;

    // directed row: request plus a hand-written result where it is obvious
    typedef struct packed {
        t_date_req rq;
        logic      typed;
        t_date_res res;
    } t_table_row;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_in_valid;
    logic                        o_in_stall;
    logic                        i_opcode;
    logic [dobd_pkg::YearW-1:0]  i_start_year;
    logic [dobd_pkg::MonthW-1:0] i_start_month;
    logic [dobd_pkg::DayW-1:0]   i_start_day;
    logic [dobd_pkg::CountW-1:0] i_day_count;
    logic                        o_out_valid;
    logic                        i_out_stall;
    logic [dobd_pkg::YearW-1:0]  o_result_year;
    logic [dobd_pkg::MonthW-1:0] o_result_month;
    logic [dobd_pkg::DayW-1:0]   o_result_day;
    logic [dobd_pkg::DoyW-1:0]   o_start_day_of_year;
    logic                        o_date_error;

    t_date_res  pending_dates[$];
    t_table_row date_table[$];

    int n_sent;
    int n_checked;
    int n_flagged;
    int n_long;
    int n_fail;
    int quiet_left;

    date_offset_by_days dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_opcode            (i_opcode),
        .i_start_year        (i_start_year),
        .i_start_month       (i_start_month),
        .i_start_day         (i_start_day),
        .i_day_count         (i_day_count),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_result_year       (o_result_year),
        .o_result_month      (o_result_month),
        .o_result_day        (o_result_day),
        .o_start_day_of_year (o_start_day_of_year),
        .o_date_error        (o_date_error)
    );

    // 12 ns clock
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // gregorian leap rule, signed years follow the same truncating modulo
    function automatic bit is_leap_year(input int y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int month_length(input int y, input int m);
        case (m)
            2:             return is_leap_year(y) ? 29 : 28;
            4, 6, 9, 11:   return 30;
            default:       return 31;
        endcase
    endfunction

    // expected result of moving a date by a day count
    function automatic t_date_res shift_date(input t_date_req rq);
        t_date_res r;
        int y;
        int m;
        int d;
        int doy;
        int i;
        r     = '0;
        r.err = 1'b1;
        y     = rq.year;
        m     = rq.month;
        d     = rq.day;
        // invalid starting date leaves everything zero but the error flag
        if (m < int'(dobd_pkg::MonthJan) || m > int'(dobd_pkg::MonthDec))
            return r;
        if (d < 1 || d > month_length(y, m))
            return r;
        doy = d;
        for (i = 1; i < m; i++)
            doy += month_length(y, i);
        r.doy = doy[dobd_pkg::DoyW-1:0];
        // month by month walk
        if (rq.op == dobd_pkg::OpAdd) begin
            d += rq.count;
            while (d > month_length(y, m)) begin
                d -= month_length(y, m);
                m++;
                if (m > 12) begin
                    m = 1;
                    y++;
                end
            end
        end else begin
            d -= rq.count;
            while (d < 1) begin
                m--;
                if (m < 1) begin
                    m = 12;
                    y--;
                end
                d += month_length(y, m);
            end
        end
        // result year out of range keeps only the day of year
        if (y < int'(dobd_pkg::YearMin) || y > int'(dobd_pkg::YearMax))
            return r;
        r.year  = y[dobd_pkg::YearW-1:0];
        r.month = m[dobd_pkg::MonthW-1:0];
        r.day   = d[dobd_pkg::DayW-1:0];
        r.err   = 1'b0;
        return r;
    endfunction

    // gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // mostly well-formed dates with small counts, some broken or far out
    function automatic t_date_req random_date();
        t_date_req rq;
        int r;
        int y;
        int m;
        r = $urandom_range(0, 99);
        if (r < 78)
            y = $urandom_range(1, 9999);
        else if (r < 84)
            y = $urandom_range(1, 60);
        else if (r < 90)
            y = $urandom_range(9940, 9999);
        else
            y = $urandom_range(0, 16383);
        if ($urandom_range(0, 99) < 92)
            m = $urandom_range(1, 12);
        else
            m = $urandom_range(0, 15);
        rq.op    = 1'($urandom_range(0, 1));
        rq.year  = y[dobd_pkg::YearW-1:0];
        rq.month = m[dobd_pkg::MonthW-1:0];
        if (m >= 1 && m <= 12 && $urandom_range(0, 99) < 90)
            rq.day = dobd_pkg::DayW'($urandom_range(1, month_length(y, m)));
        else
            rq.day = dobd_pkg::DayW'($urandom_range(0, 31));
        r = $urandom_range(0, 99);
        if (r < 55)
            rq.count = dobd_pkg::CountW'($urandom_range(0, 60));
        else if (r < 75)
            rq.count = dobd_pkg::CountW'($urandom_range(61, 800));
        else if (r < 90)
            rq.count = dobd_pkg::CountW'($urandom_range(0, 65535));
        else
            case ($urandom_range(0, 3))
                0:       rq.count = 16'hffff;
                1:       rq.count = 16'h8000;
                2:       rq.count = 16'hfffe;
                default: rq.count = 16'h0000;
            endcase
        return rq;
    endfunction

    task automatic add_row(input logic op, input int y, input int m, input int d,
                           input int n, input bit typed, input int ry, input int rm,
                           input int rd, input int rdoy, input bit rerr);
        t_table_row row;
        row.rq.op     = op;
        row.rq.year   = y[dobd_pkg::YearW-1:0];
        row.rq.month  = m[dobd_pkg::MonthW-1:0];
        row.rq.day    = d[dobd_pkg::DayW-1:0];
        row.rq.count  = n[dobd_pkg::CountW-1:0];
        row.typed     = typed;
        row.res.year  = ry[dobd_pkg::YearW-1:0];
        row.res.month = rm[dobd_pkg::MonthW-1:0];
        row.res.day   = rd[dobd_pkg::DayW-1:0];
        row.res.doy   = rdoy[dobd_pkg::DoyW-1:0];
        row.res.err   = rerr;
        date_table.push_back(row);
    endtask

    // present one request, hold it until the transfer, then maybe idle
    task automatic send_date(input t_date_req rq, input bit typed, input t_date_res res);
        int gap;
        i_in_valid    <= 1'b1;
        i_opcode      <= rq.op;
        i_start_year  <= rq.year;
        i_start_month <= rq.month;
        i_start_day   <= rq.day;
        i_day_count   <= rq.count;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        pending_dates.push_back(typed ? res : shift_date(rq));
        n_sent++;
        if (rq.count > 30000)
            n_long++;
        // occasional stretch of back-to-back transfers
        if (quiet_left > 0) begin
            quiet_left--;
            gap = 0;
        end else begin
            if ($urandom_range(0, 99) < 5)
                quiet_left = $urandom_range(15, 30);
            gap = pick_gap();
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // hold the sender until every outstanding result is back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_dates.size() != 0)
            @(posedge i_clk);
    endtask

    // receiver stall pattern
    initial begin
        int run;
        i_out_stall <= 1'b0;
        forever begin
            if ($urandom_range(0, 9) == 0) begin
                i_out_stall <= 1'b0;
                repeat ($urandom_range(200, 800)) @(posedge i_clk);
            end else begin
                run = $urandom_range(1, 30);
                i_out_stall <= 1'b0;
                repeat (run) @(posedge i_clk);
                i_out_stall <= 1'b1;
                repeat (1 + pick_gap()) @(posedge i_clk);
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_date_res got;
        t_date_res exp_res;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.year  = o_result_year;
            got.month = o_result_month;
            got.day   = o_result_day;
            got.doy   = o_start_day_of_year;
            got.err   = o_date_error;
            if (pending_dates.size() == 0) begin
                n_fail++;
                if (n_fail <= 10)
                    $display("unexpected result transfer: %0d-%0d-%0d doy %0d err %0b",
                             got.year, got.month, got.day, got.doy, got.err);
            end else begin
                exp_res = pending_dates.pop_front();
                n_checked++;
                if (got.err)
                    n_flagged++;
                if (got !== exp_res) begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display({"mismatch on result %0d: expected %0d-%0d-%0d doy %0d ",
                                  "err %0b, got %0d-%0d-%0d doy %0d err %0b"},
                                 n_checked, exp_res.year, exp_res.month, exp_res.day,
                                 exp_res.doy, exp_res.err, got.year, got.month, got.day,
                                 got.doy, got.err);
                end
            end
        end
    end

    // main stimulus
    initial begin
        int k;
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_opcode      <= dobd_pkg::OpAdd;
        i_start_year  <= '0;
        i_start_month <= '0;
        i_start_day   <= '0;
        i_day_count   <= '0;
        n_sent        = 0;
        n_checked     = 0;
        n_flagged     = 0;
        n_long        = 0;
        n_fail        = 0;
        quiet_left    = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows: op, y, m, d, count, typed, then year, month, day, doy, err
        add_row(dobd_pkg::OpAdd,  2024,  1,  1,     0, 1, 2024,  1,  1,   1, 0);
        add_row(dobd_pkg::OpSub,  2023,  7, 15,     0, 1, 2023,  7, 15, 196, 0);
        add_row(dobd_pkg::OpAdd,  2000, 12, 31,     0, 1, 2000, 12, 31, 366, 0);
        add_row(dobd_pkg::OpAdd,  2000,  2, 29,     0, 1, 2000,  2, 29,  60, 0);
        add_row(dobd_pkg::OpAdd,  2024, 12, 31,     1, 1, 2025,  1,  1, 366, 0);
        add_row(dobd_pkg::OpSub,  2024,  3,  1,     1, 1, 2024,  2, 29,  61, 0);
        add_row(dobd_pkg::OpAdd,  1900,  2, 28,     1, 1, 1900,  3,  1,  59, 0);
        add_row(dobd_pkg::OpSub, 10000,  1,  1,     1, 1, 9999, 12, 31,   1, 0);
        // bad starting dates
        add_row(dobd_pkg::OpAdd,  2020,  0, 15,     5, 1,    0,  0,  0,   0, 1);
        add_row(dobd_pkg::OpAdd,  2020, 13, 15,     5, 1,    0,  0,  0,   0, 1);
        add_row(dobd_pkg::OpSub,  2020, 15, 31,     5, 1,    0,  0,  0,   0, 1);
        add_row(dobd_pkg::OpAdd,  2021,  5,  0,     5, 1,    0,  0,  0,   0, 1);
        add_row(dobd_pkg::OpAdd,  2021,  4, 31,     5, 1,    0,  0,  0,   0, 1);
        add_row(dobd_pkg::OpAdd,  1900,  2, 29,     5, 1,    0,  0,  0,   0, 1);
        add_row(dobd_pkg::OpSub,  2100,  2, 29,     5, 1,    0,  0,  0,   0, 1);
        // result year out of range
        add_row(dobd_pkg::OpAdd,  9999, 12, 31,     1, 1,    0,  0,  0, 365, 1);
        add_row(dobd_pkg::OpSub,     1,  1,  1,     1, 1,    0,  0,  0,   1, 1);
        add_row(dobd_pkg::OpAdd,  9999, 12, 31, 65535, 1,    0,  0,  0, 365, 1);
        add_row(dobd_pkg::OpSub,     1,  1,  1, 65535, 1,    0,  0,  0,   1, 1);
        add_row(dobd_pkg::OpAdd,     0,  3,  1,     0, 1,    0,  0,  0,  61, 1);
        add_row(dobd_pkg::OpSub, 16383, 12, 31, 65535, 1,    0,  0,  0, 365, 1);
        // longest walks and year zero
        add_row(dobd_pkg::OpAdd,     1,  1,  1, 65535, 0,    0,  0,  0,   0, 0);
        add_row(dobd_pkg::OpSub,  9999, 12, 31, 65535, 0,    0,  0,  0,   0, 0);
        add_row(dobd_pkg::OpAdd,     0,  6, 15,   400, 0,    0,  0,  0,   0, 0);
        add_row(dobd_pkg::OpSub,  2023,  6, 30, 32768, 0,    0,  0,  0,   0, 0);

        foreach (date_table[j])
            send_date(date_table[j].rq, date_table[j].typed, date_table[j].res);
        drain_results();

        // random part, with one more full drain half way
        for (k = 0; k < 270; k++) begin
            if (k == 135)
                drain_results();
            send_date(random_date(), 1'b0, '0);
        end
        i_in_valid <= 1'b0;

        // wait out the tail
        while (pending_dates.size() != 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);

        $display("%0d dates moved and checked, %0d of them flagged as errors,",
                 n_checked, n_flagged);
        $display("%0d walks longer than 30000 days, %0d failures", n_long, n_fail);
        if (n_fail == 0 && pending_dates.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // hang guard
    initial begin
        #50_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
